// ===== src/ccl_pkg.sv =====
// ----------------------------------------------------------------------------
// ccl_pkg
// types, codes and character helpers shared by the command line parser
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned ColorW  = 24;
    localparam int unsigned LevelW  = 8;
    localparam int unsigned KeyLen  = 9;
    localparam int unsigned ColorDigits = 6;

    localparam logic [CharW-1:0] ChNul   = 8'h00;
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChTab   = 8'h09;
    localparam logic [CharW-1:0] ChHash  = 8'h23;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChLowX  = 8'h78;
    localparam logic [CharW-1:0] ChUpX   = 8'h58;

    typedef enum logic [3:0] {
        PH_LEAD  = 4'd0,
        PH_KEY   = 4'd1,
        PH_GAP1  = 4'd2,
        PH_COLOR = 4'd3,
        PH_GAP2  = 4'd4,
        PH_PFX   = 4'd5,
        PH_FIRST = 4'd6,
        PH_LEVEL = 4'd7,
        PH_TRAIL = 4'd8,
        PH_ERR   = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_MISSING  = 3'd3,
        ST_COLOR    = 3'd4,
        ST_LEVEL    = 3'd5,
        ST_TRAILING = 3'd6
    } t_status;

    typedef struct packed {
        t_phase              phase;
        logic [3:0]          match_index;
        logic [2:0]          digit_count;
        logic [ColorW-1:0]   color;
        logic [LevelW-1:0]   level;
        t_status             error_code;
    } t_parse_state;

    typedef struct packed {
        t_status             status;
        logic [ColorW-1:0]   color;
        logic [LevelW-1:0]   level;
    } t_result;

    localparam t_parse_state ParseReset = '{
        phase:       PH_LEAD,
        match_index: 4'd0,
        digit_count: 3'd0,
        color:       '0,
        level:       '0,
        error_code:  ST_OK
    };

    function automatic logic [CharW-1:0] key_char(input logic [3:0] idx);
        logic [CharW-1:0] c;
        unique case (idx)
            4'd0:    c = 8'h73; // s
            4'd1:    c = 8'h65; // e
            4'd2:    c = 8'h74; // t
            4'd3:    c = 8'h5f; // _
            4'd4:    c = 8'h63; // c
            4'd5:    c = 8'h6f; // o
            4'd6:    c = 8'h6c; // l
            4'd7:    c = 8'h6f; // o
            4'd8:    c = 8'h72; // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [CharW-1:0] c);
        return (c == ChSpace) || (c == ChTab);
    endfunction

    // {digit flag, digit value}
    function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
        logic [CharW-1:0] t;
        logic [4:0]       r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            r = {1'b1, t[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            r = {1'b1, t[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

endpackage

// ===== src/ccl_step.sv =====
// ----------------------------------------------------------------------------
// ccl_step
// one character step of the parser: next state and line result
// ----------------------------------------------------------------------------
module ccl_step (
    input  ccl_pkg::t_parse_state        i_state,
    input  logic [ccl_pkg::CharW-1:0]    i_ch,
    output ccl_pkg::t_parse_state        o_state,
    output logic                         o_done,
    output ccl_pkg::t_result             o_result
);
    import ccl_pkg::*;

    t_parse_state s;
    logic [4:0]   hv;
    logic         dig;
    logic         blank;
    logic         nul;
    logic [11:0]  v;

    always_comb begin
        s     = i_state;
        hv    = hex_value(i_ch);
        dig   = hv[4];
        blank = is_blank(i_ch);
        nul   = (i_ch == ChNul);
        v     = {i_state.level, hv[3:0]};

        unique case (i_state.phase)
            PH_LEAD: begin
                if (blank) begin
                end else if (nul) begin
                    s.error_code = ST_EMPTY;
                    s.phase      = PH_ERR;
                end else if (i_ch == key_char(4'd0)) begin
                    s.phase       = PH_KEY;
                    s.match_index = 4'd1;
                end else begin
                    s.error_code = ST_UNKNOWN;
                    s.phase      = PH_ERR;
                end
            end
            PH_KEY: begin
                if (i_state.match_index < 4'(KeyLen)) begin
                    if (i_ch == key_char(i_state.match_index)) begin
                        s.match_index = i_state.match_index + 4'd1;
                    end else begin
                        s.error_code = ST_UNKNOWN;
                        s.phase      = PH_ERR;
                    end
                end else if (blank) begin
                    s.phase = PH_GAP1;
                end else begin
                    s.error_code = ST_UNKNOWN;
                    s.phase      = PH_ERR;
                end
            end
            PH_GAP1: begin
                if (blank) begin
                end else if (nul) begin
                    s.error_code = ST_MISSING;
                    s.phase      = PH_ERR;
                end else if (i_ch == ChHash) begin
                    s.phase       = PH_COLOR;
                    s.digit_count = 3'd0;
                    s.color       = '0;
                end else begin
                    s.error_code = ST_COLOR;
                    s.phase      = PH_ERR;
                end
            end
            PH_COLOR: begin
                if (i_state.digit_count < 3'(ColorDigits)) begin
                    if (dig) begin
                        s.color       = {i_state.color[ColorW-5:0], hv[3:0]};
                        s.digit_count = i_state.digit_count + 3'd1;
                    end else begin
                        s.color      = '0;
                        s.error_code = ST_COLOR;
                        s.phase      = PH_ERR;
                    end
                end else if (blank) begin
                    s.phase = PH_GAP2;
                end else begin
                    s.color      = '0;
                    s.error_code = ST_COLOR;
                    s.phase      = PH_ERR;
                end
            end
            PH_GAP2: begin
                if (blank) begin
                end else if (nul) begin
                    s.error_code = ST_MISSING;
                    s.phase      = PH_ERR;
                end else if (i_ch == ChZero) begin
                    s.phase = PH_PFX;
                end else begin
                    s.error_code = ST_LEVEL;
                    s.phase      = PH_ERR;
                end
            end
            PH_PFX: begin
                if (i_ch == ChLowX || i_ch == ChUpX) begin
                    s.phase = PH_FIRST;
                end else begin
                    s.error_code = ST_LEVEL;
                    s.phase      = PH_ERR;
                end
            end
            PH_FIRST: begin
                if (dig) begin
                    s.level = {4'd0, hv[3:0]};
                    s.phase = PH_LEVEL;
                end else begin
                    s.error_code = ST_LEVEL;
                    s.phase      = PH_ERR;
                end
            end
            PH_LEVEL: begin
                if (dig) begin
                    if (v > 12'hff) begin
                        s.level      = '0;
                        s.error_code = ST_LEVEL;
                        s.phase      = PH_ERR;
                    end else begin
                        s.level = v[LevelW-1:0];
                    end
                end else if (blank) begin
                    s.phase = PH_TRAIL;
                end else if (!nul) begin
                    s.error_code = ST_TRAILING;
                    s.phase      = PH_ERR;
                end
            end
            PH_TRAIL: begin
                if (!nul && !blank) begin
                    s.error_code = ST_TRAILING;
                    s.phase      = PH_ERR;
                end
            end
            default: begin
            end
        endcase

        o_result.status = s.error_code;
        o_result.color  = s.color;
        o_result.level  = s.level;
        o_done          = nul;
        o_state         = nul ? ParseReset : s;
    end

endmodule

// ===== src/color_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// color_command_line_parser
// color command line checker, one character per item
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall with one character in i_ch; a zero
// character ends the line
// output channel: o_valid / i_stall with o_status, o_red, o_green, o_blue
// and o_brightness, one item per line, sent for the terminating character
// a character is registered at acceptance and parsed from that register;
// the line result is registered when the terminator is stepped; a new line
// may start right after a terminator. throughput: one character per cycle,
// set by the single registered parse step, unless a terminator must wait
// reset: parse state returns to the leading blank phase and both the input
// and result registers are emptied
// when the receiver stalls, the result is held; ordinary characters keep
// flowing, and only a terminator waits until the result register is free,
// with o_stall high for the input side while it waits
// ----------------------------------------------------------------------------
module color_command_line_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ccl_pkg::CharW-1:0]   i_ch,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_status,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_blue,
    output logic [ccl_pkg::LevelW-1:0]  o_brightness
);
    import ccl_pkg::*;

    logic               r_in_valid;
    logic [CharW-1:0]   r_in_ch;
    t_parse_state       r_state;
    logic               r_out_valid;
    t_result            r_out;

    t_parse_state       n_state;
    t_result            step_result;
    logic               step_done;
    logic               advance;
    logic               accept;

    ccl_step u_step (
        .i_state  (r_state),
        .i_ch     (r_in_ch),
        .o_state  (n_state),
        .o_done   (step_done),
        .o_result (step_result)
    );

    assign advance = r_in_valid && (!step_done || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ParseReset;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_done) begin
            r_out <= step_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out.status;
    assign o_red        = r_out.color[23:16];
    assign o_green      = r_out.color[15:8];
    assign o_blue       = r_out.color[7:0];
    assign o_brightness = r_out.level;

endmodule

// ===== sim/color_command_line_parser_checker.sv =====
// ----------------------------------------------------------------------------
// color_command_line_parser_checker
// watches both channels of the parser, predicts each line result and compares
// ----------------------------------------------------------------------------
// every accepted character steps a private copy of the parse state; a zero
// character queues the expected line result and clears that state. each
// accepted result is compared field by field against the oldest queued line
// result. the failure count, the number of results still awaited and a mask
// of the status codes seen go to the testbench top
// ----------------------------------------------------------------------------
module color_command_line_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ch_valid,
    input  logic        i_ch_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_brightness,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output logic [6:0]  o_status_seen
);
    import ccl_pkg::*;

    // keyword bytes, first character in the top byte
    localparam logic [8*KeyLen-1:0] KeyWord = 72'h73_65_74_5f_63_6f_6c_6f_72;
    localparam int MaxReports = 10;

    typedef struct {
        t_status    status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] level;
    } line_result_t;

    line_result_t line_results_q[$];

    t_phase      phase_q;
    logic [3:0]  key_pos;
    logic [2:0]  color_digits;
    logic [23:0] color_acc;
    logic [8:0]  level_acc;
    t_status     err_q;

    function automatic bit blank_char(input logic [7:0] c);
        return (c == ChSpace) || (c == ChTab);
    endfunction

    // -1 for anything that is not a hex digit
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic clear_line();
        phase_q      = PH_LEAD;
        key_pos      = '0;
        color_digits = '0;
        color_acc    = '0;
        level_acc    = '0;
        err_q        = ST_OK;
    endtask

    task automatic reject_line(input t_status code);
        err_q   = code;
        phase_q = PH_ERR;
    endtask

    task automatic parse_char(input logic [7:0] c);
        int           d;
        int           v;
        line_result_t r;
        d = hex_digit(c);
        if (phase_q == PH_LEAD) begin
            if (c == ChNul) begin
                reject_line(ST_EMPTY);
            end else if (!blank_char(c)) begin
                phase_q = PH_KEY;
                key_pos = '0;
            end
        end
        case (phase_q)
            PH_KEY: begin
                if (key_pos < KeyLen) begin
                    if (c == KeyWord[8*(KeyLen-1-key_pos) +: 8]) key_pos = key_pos + 4'd1;
                    else reject_line(ST_UNKNOWN);
                end else if (blank_char(c)) begin
                    phase_q = PH_GAP1;
                end else begin
                    reject_line(ST_UNKNOWN);
                end
            end
            PH_GAP1: begin
                if (c == ChNul) begin
                    reject_line(ST_MISSING);
                end else if (c == ChHash) begin
                    phase_q      = PH_COLOR;
                    color_digits = '0;
                    color_acc    = '0;
                end else if (!blank_char(c)) begin
                    reject_line(ST_COLOR);
                end
            end
            PH_COLOR: begin
                if (color_digits < ColorDigits) begin
                    if (d < 0) begin
                        color_acc = '0;
                        reject_line(ST_COLOR);
                    end else begin
                        color_acc    = {color_acc[19:0], 4'(d)};
                        color_digits = color_digits + 3'd1;
                    end
                end else if (blank_char(c)) begin
                    phase_q = PH_GAP2;
                end else begin
                    color_acc = '0;
                    reject_line(ST_COLOR);
                end
            end
            PH_GAP2: begin
                if (c == ChNul) reject_line(ST_MISSING);
                else if (c == ChZero) phase_q = PH_PFX;
                else if (!blank_char(c)) reject_line(ST_LEVEL);
            end
            PH_PFX: begin
                if (c == ChLowX || c == ChUpX) phase_q = PH_FIRST;
                else reject_line(ST_LEVEL);
            end
            PH_FIRST: begin
                if (d < 0) begin
                    reject_line(ST_LEVEL);
                end else begin
                    level_acc = 9'(d);
                    phase_q   = PH_LEVEL;
                end
            end
            PH_LEVEL: begin
                if (d >= 0) begin
                    v = int'(level_acc) * 16 + d;
                    if (v > 255) begin
                        level_acc = '0;
                        reject_line(ST_LEVEL);
                    end else begin
                        level_acc = 9'(v);
                    end
                end else if (blank_char(c)) begin
                    phase_q = PH_TRAIL;
                end else if (c != ChNul) begin
                    reject_line(ST_TRAILING);
                end
            end
            PH_TRAIL: begin
                if (c != ChNul && !blank_char(c)) reject_line(ST_TRAILING);
            end
            default: ;
        endcase
        if (c == ChNul) begin
            r.status = err_q;
            r.red    = color_acc[23:16];
            r.green  = color_acc[15:8];
            r.blue   = color_acc[7:0];
            r.level  = level_acc[7:0];
            line_results_q.push_back(r);
            clear_line();
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            if (o_fail_count < MaxReports)
                $display("mismatch in result %0d, %s: expected %0d, got %0d",
                         o_checked, name, exp_v, act_v);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        line_result_t exp_r;
        if (!i_rst_n) begin
            clear_line();
            line_results_q.delete();
            o_fail_count  = 0;
            o_checked     = 0;
            o_status_seen = '0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (line_results_q.size() == 0) begin
                    if (o_fail_count < MaxReports)
                        $display("result with no line pending: status %0d", i_status);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_r = line_results_q.pop_front();
                    check_field("status", exp_r.status, i_status);
                    check_field("red", exp_r.red, i_red);
                    check_field("green", exp_r.green, i_green);
                    check_field("blue", exp_r.blue, i_blue);
                    check_field("brightness", exp_r.level, i_brightness);
                    o_status_seen[exp_r.status] = 1'b1;
                end
                o_checked = o_checked + 1;
            end
            if (i_ch_valid && !i_ch_stall) parse_char(i_ch);
        end
        o_pending <= line_results_q.size();
    end

endmodule

// ===== sim/color_command_line_parser_tb.sv =====
// ----------------------------------------------------------------------------
// color_command_line_parser_tb
// regression of the color command line parser
// ----------------------------------------------------------------------------
// directed lines walk every status code and the field extremes, then random
// lines follow: mostly well-formed commands with random blanks, hex case,
// colors and brightness, the rest mangled commands and raw byte noise. both
// sides stall at random, with one quiet stretch. the checker module predicts
// and compares; this top drives characters and gives the verdict
// ----------------------------------------------------------------------------
module color_command_line_parser_tb;
    import ccl_pkg::*;

    localparam int CharTarget = 1500;
    localparam int CycleLimit = 200000;
    // keyword bytes, first character in the top byte
    localparam logic [8*KeyLen-1:0] KeyWord = 72'h73_65_74_5f_63_6f_6c_6f_72;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_brightness;

    int          fail_count;
    int          pending;
    int          checked;
    logic [6:0]  status_seen;
    int          chars_sent;
    int          lines_sent;
    int          cycle_count;
    logic        calm;
    logic [7:0]  line_buf[$];

    color_command_line_parser DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_brightness (o_brightness)
    );

    color_command_line_parser_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch_valid    (i_valid),
        .i_ch_stall    (o_stall),
        .i_ch          (i_ch),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_status      (o_status),
        .i_red         (o_red),
        .i_green       (o_green),
        .i_blue        (o_blue),
        .i_brightness  (o_brightness),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    // no idling on either side in this window
    assign calm = (chars_sent >= 600) && (chars_sent < 900);

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_stall = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !calm && ($urandom_range(99) < 28);
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d lines still pending", cycle_count, pending);
            $display("color_command_line_parser regression: fail");
            $finish;
        end
    end

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic put_key();
        for (int i = 0; i < KeyLen; i++) line_buf.push_back(KeyWord[8*(KeyLen-1-i) +: 8]);
    endtask

    task automatic put_blanks(input int lo, input int hi);
        repeat ($urandom_range(hi, lo)) line_buf.push_back($urandom_range(1) ? ChSpace : ChTab);
    endtask

    task automatic put_hex(input int d);
        if (d < 10) line_buf.push_back(8'(int'("0") + d));
        else if ($urandom_range(1)) line_buf.push_back(8'(int'("a") + d - 10));
        else line_buf.push_back(8'(int'("A") + d - 10));
    endtask

    task automatic send_char(input logic [7:0] c);
        while (!calm && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent = chars_sent + 1;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i]);
        send_char(ChNul);
        lines_sent = lines_sent + 1;
        line_buf.delete();
    endtask

    task automatic run_text(input string s);
        line_buf.delete();
        put_text(s);
        send_line();
    endtask

    // leading text, keyword, then the rest of the line
    task automatic run_cmd(input string lead, input string tail);
        line_buf.delete();
        put_text(lead);
        put_key();
        put_text(tail);
        send_line();
    endtask

    initial begin
        int kind;
        int pos;
        int lvl;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ch       = '0;
        chars_sent = 0;
        lines_sent = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed lines
        run_cmd("", " #FF8000 0x80");
        run_text("");
        run_text("  \t ");
        run_text("set_colour #112233 0x10");
        run_cmd("", "");
        run_cmd("", "#112233 0x1");
        run_cmd("", " ");
        run_cmd("", " #");
        run_cmd("", " #12345 0x10");
        run_cmd("", " #12G456 0x10");
        run_cmd("", " #123456x 0x10");
        run_cmd("", " #123456");
        run_cmd("", " #abcdef ");
        run_cmd("", " #ABCDEF 1x20");
        run_cmd("", " #ABCDEF 0y20");
        run_cmd("", " #ABCDEF 0x");
        run_cmd("", " #ABCDEF 0x100");
        run_cmd("", " #ABCDEF 0XfF  \t");
        run_cmd("", " #000000 0x00 z");
        run_cmd("", " #ffffff 0x0g");
        run_cmd("\t ", "\t \t#0a0B0c\t0x7");
        run_cmd("", " #123456 0x0001");
        run_cmd("", " 123456 0x1");
        line_buf.delete();
        put_text("set_colo");
        line_buf.push_back(8'hf2);
        send_line();
        line_buf.delete();
        put_key();
        put_text(" #FFFFFF 0xff ");
        line_buf.push_back(8'hff);
        send_line();

        // random lines
        while (chars_sent < CharTarget) begin
            kind = $urandom_range(99);
            line_buf.delete();
            if (kind < 8) begin
                repeat ($urandom_range(12)) begin
                    if ($urandom_range(3) == 0) line_buf.push_back(ChSpace);
                    else line_buf.push_back(8'($urandom_range(255, 1)));
                end
            end else begin
                put_blanks(0, 3);
                put_key();
                put_blanks(1, 3);
                line_buf.push_back(ChHash);
                repeat (ColorDigits) put_hex($urandom_range(15));
                put_blanks(1, 3);
                line_buf.push_back(ChZero);
                line_buf.push_back($urandom_range(1) ? ChLowX : ChUpX);
                lvl = $urandom_range(255);
                repeat ($urandom_range(2)) put_hex(0);
                if (lvl > 15) put_hex(lvl >> 4);
                put_hex(lvl & 15);
                if ($urandom_range(9) == 0) put_hex($urandom_range(15));
                put_blanks(0, 2);
                if (kind >= 68) begin
                    pos = $urandom_range(line_buf.size() - 1);
                    case ($urandom_range(3))
                        0: line_buf[pos] = 8'($urandom_range(255, 1));
                        1: line_buf.delete(pos);
                        2: while (line_buf.size() > pos) void'(line_buf.pop_back());
                        default: line_buf.insert(pos, 8'($urandom_range(255, 1)));
                    endcase
                end
            end
            send_line();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d lines in %0d characters, %0d line results checked",
                 lines_sent, chars_sent, checked);
        $display("status codes seen (bit per code, 6 down to 0): %b", status_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("color_command_line_parser regression: pass");
        end else begin
            $display("%0d mismatches, %0d lines without result", fail_count, pending);
            $display("color_command_line_parser regression: fail");
        end
        $finish;
    end

endmodule
